// ----- design/afrb_pkg.sv -----
package afrb_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FIELD_LANES = 4;
    localparam int BLOCK_W     = 7;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_FRAMES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_IN_USE = 2'd1;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    typedef struct packed {
        logic [1:0]                 command;
        logic [BLOCK_W-1:0]         block_frames;
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
    } in_item_t;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] out_sample_0;
        logic signed [SAMPLE_W-1:0] out_sample_1;
        logic signed [SAMPLE_W-1:0] out_sample_2;
        logic signed [SAMPLE_W-1:0] out_sample_3;
        logic                       underflow;
        logic                       write_allowed;
        logic                       last_frame;
        logic [COUNT_W-1:0]         frames_total;
    } out_item_t;

    typedef struct packed {
        logic accept_write;
        logic accept_read;
        logic accept_check;
        logic accept_clear;
        logic advance;
        logic finish;
        logic sweep;
    } ctrl_t;

    typedef struct packed {
        logic block_zero;
        logic last_beat;
        logic sweep_done;
    } stat_t;

endpackage

// ----- design/afrb_ram.sv -----
module afrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/afrb_ctrl.sv -----
module afrb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      command,
    output logic            out_valid,
    input  logic            out_ready,
    input  afrb_pkg::stat_t stat,
    output afrb_pkg::ctrl_t ctl
);

    import afrb_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SHOW  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_beat;
    logic       out_beat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SHOW);
    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid && out_ready;

    always_comb
    begin
        ctl            = '0;
        ctl.sweep      = (state_reg == ST_CLEAR);
        ctl.advance    = out_beat && !stat.last_beat;
        ctl.finish     = out_beat && stat.last_beat;
        state_next     = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (command)
                        CMD_WRITE: ctl.accept_write = 1'b1;
                        CMD_READ:
                        begin
                            ctl.accept_read = 1'b1;
                            if (!stat.block_zero)
                            begin
                                state_next = ST_SHOW;
                            end
                        end
                        CMD_CHECK:
                        begin
                            ctl.accept_check = 1'b1;
                            state_next       = ST_SHOW;
                        end
                        CMD_CLEAR:
                        begin
                            ctl.accept_clear = 1'b1;
                            state_next       = ST_CLEAR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SHOW:
            begin
                if (ctl.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output beats open together");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!in_ready && !out_valid))
        else $error("beat open during sweep");

endmodule

// ----- design/afrb_datapath.sv -----
module afrb_datapath #(
    parameter int DEPTH_FRAMES = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_BLOCK    = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [afrb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [afrb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  afrb_pkg::in_item_t                    in_item,
    input  afrb_pkg::ctrl_t                       ctl,
    output afrb_pkg::stat_t                       stat,
    output afrb_pkg::out_item_t                   out_item
);

    import afrb_pkg::*;

    localparam int PW = $clog2(DEPTH_FRAMES);
    localparam int SW = ($clog2(DEPTH_FRAMES + 1) < CFG_DATA_W) ?
                        $clog2(DEPTH_FRAMES + 1) : CFG_DATA_W;
    localparam int AW = (PW + 2 > 8) ? PW + 2 : 8;
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int LANES = (MAX_CHANNELS < FIELD_LANES) ? MAX_CHANNELS : FIELD_LANES;
    localparam int SIZE_RESET = (DEPTH_FRAMES < 1024) ? DEPTH_FRAMES : 1024;
    localparam int CH_RESET = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

    logic [SW-1:0]      size_reg;
    logic [CW-1:0]      ch_reg;
    logic [PW-1:0]      wp_reg;
    logic [PW-1:0]      rp_reg;
    logic [PW-1:0]      fp_reg;
    logic [PW-1:0]      sweep_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [BLOCK_W-1:0] left_reg;
    logic               kind_reg;
    logic               under_reg;
    logic               allowed_reg;

    logic [AW-1:0]      size_a;
    logic [AW-1:0]      wp_a;
    logic [AW-1:0]      rp_a;
    logic [AW-1:0]      pending;
    logic [AW-1:0]      latency;
    logic [BLOCK_W-1:0] blk_sat;
    logic               under_now;
    logic               allowed_now;
    logic [31:0]        cfg_size32;
    logic [31:0]        cfg_ch32;
    logic [SW-1:0]      size_new;
    logic [AW-1:0]      wp_inc;
    logic [AW-1:0]      rd_inc;
    logic               rd_en;
    logic [PW-1:0]      rd_addr;
    logic [PW-1:0]      wr_addr;
    logic               show_data;

    logic signed [SAMPLE_W-1:0] in_lane  [FIELD_LANES];
    logic signed [SAMPLE_W-1:0] out_lane [FIELD_LANES];
    logic [SAMPLE_W-1:0]        rdata    [LANES];

    assign size_a = AW'(size_reg);
    assign wp_a   = AW'(wp_reg);
    assign rp_a   = AW'(rp_reg);

    assign blk_sat = (32'(in_item.block_frames) > 32'(MAX_BLOCK)) ?
                     BLOCK_W'(MAX_BLOCK) : in_item.block_frames;

    assign pending = (wp_a >= rp_a) ? wp_a - rp_a : wp_a + size_a - rp_a;
    assign latency = (rp_a >= wp_a) ? rp_a - wp_a : rp_a + size_a - wp_a;
    assign under_now   = AW'(blk_sat) > pending;
    assign allowed_now = !((latency != '0) && (latency < AW'({blk_sat, 1'b0})));

    assign stat.block_zero = (blk_sat == '0);
    assign stat.last_beat  = (left_reg == BLOCK_W'(1));
    assign stat.sweep_done = (sweep_reg == PW'(DEPTH_FRAMES - 1));

    always_comb
    begin
        cfg_size32 = 32'(cfg_data);
        if (cfg_size32 < 32'd2)
        begin
            cfg_size32 = 32'd2;
        end
        if (cfg_size32 > 32'(DEPTH_FRAMES))
        begin
            cfg_size32 = 32'(DEPTH_FRAMES);
        end
        cfg_ch32 = 32'(cfg_data[2:0]);
        if (cfg_ch32 < 32'd1)
        begin
            cfg_ch32 = 32'd1;
        end
        if (cfg_ch32 > 32'(MAX_CHANNELS))
        begin
            cfg_ch32 = 32'(MAX_CHANNELS);
        end
    end

    assign size_new = cfg_size32[SW-1:0];

    assign wp_inc  = (wp_a + AW'(1) == size_a) ? '0 : wp_a + AW'(1);
    assign rd_en   = (ctl.accept_read && !under_now && !stat.block_zero) ||
                     (ctl.advance && !under_reg && (kind_reg == KIND_READ));
    assign rd_addr = ctl.accept_read ? rp_reg : fp_reg;
    assign rd_inc  = (AW'(rd_addr) + AW'(1) == size_a) ? '0 : AW'(rd_addr) + AW'(1);
    assign wr_addr = ctl.sweep ? sweep_reg : wp_reg;

    assign in_lane[0] = in_item.sample_0;
    assign in_lane[1] = in_item.sample_1;
    assign in_lane[2] = in_item.sample_2;
    assign in_lane[3] = in_item.sample_3;

    assign show_data = (kind_reg == KIND_READ) && !under_reg;

    for (genvar c = 0; c < FIELD_LANES; c++)
    begin : g_lane
        if (c < LANES)
        begin : g_used
            logic lane_on;
            assign lane_on = ch_reg > CW'(c);
            afrb_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (DEPTH_FRAMES)
            ) u_ram (
                .clk   (clk),
                .we    (ctl.sweep || (ctl.accept_write && lane_on)),
                .waddr (wr_addr),
                .wdata (ctl.sweep ? '0 : in_lane[c]),
                .re    (rd_en),
                .raddr (rd_addr),
                .rdata (rdata[c])
            );
            assign out_lane[c] = (show_data && lane_on) ? rdata[c] : '0;
        end
        else
        begin : g_unused
            assign out_lane[c] = '0;
        end
    end

    assign out_item.kind          = kind_reg;
    assign out_item.out_sample_0  = out_lane[0];
    assign out_item.out_sample_1  = out_lane[1];
    assign out_item.out_sample_2  = out_lane[2];
    assign out_item.out_sample_3  = out_lane[3];
    assign out_item.underflow     = under_reg;
    assign out_item.write_allowed = allowed_reg;
    assign out_item.last_frame    = stat.last_beat;
    assign out_item.frames_total  = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SW'(SIZE_RESET);
            ch_reg      <= CW'(CH_RESET);
            wp_reg      <= '0;
            rp_reg      <= '0;
            fp_reg      <= '0;
            sweep_reg   <= '0;
            count_reg   <= '0;
            left_reg    <= '0;
            kind_reg    <= KIND_READ;
            under_reg   <= 1'b0;
            allowed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_BUFFER_FRAMES))
            begin
                size_reg <= size_new;
                if (wp_a >= AW'(size_new))
                begin
                    wp_reg <= '0;
                end
                if (rp_a >= AW'(size_new))
                begin
                    rp_reg <= '0;
                end
            end
            if (cfg_we && (cfg_index == CFG_CHANNELS_IN_USE))
            begin
                ch_reg <= cfg_ch32[CW-1:0];
            end

            if (ctl.accept_write)
            begin
                wp_reg    <= wp_inc[PW-1:0];
                count_reg <= count_reg + COUNT_W'(1);
            end

            if (ctl.accept_clear)
            begin
                wp_reg    <= '0;
                rp_reg    <= '0;
                count_reg <= '0;
                sweep_reg <= '0;
            end
            else if (ctl.sweep && !stat.sweep_done)
            begin
                sweep_reg <= sweep_reg + PW'(1);
            end

            if (rd_en)
            begin
                fp_reg <= rd_inc[PW-1:0];
            end

            if (ctl.accept_read)
            begin
                kind_reg    <= KIND_READ;
                under_reg   <= under_now;
                allowed_reg <= 1'b0;
                left_reg    <= blk_sat;
            end
            else if (ctl.accept_check)
            begin
                kind_reg    <= KIND_CHECK;
                under_reg   <= 1'b0;
                allowed_reg <= allowed_now;
                left_reg    <= BLOCK_W'(1);
            end
            else if (ctl.advance)
            begin
                left_reg <= left_reg - BLOCK_W'(1);
            end

            if (ctl.finish && (kind_reg == KIND_READ) && !under_reg)
            begin
                rp_reg <= fp_reg;
            end
        end
    end

    a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        AW'(wp_reg) < size_a)
        else $error("write position outside ring");

    a_rp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        AW'(rp_reg) < size_a)
        else $error("read position outside ring");

    a_rp_moves_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.advance && !cfg_we) |=> $stable(rp_reg))
        else $error("read position moved mid block");

endmodule

// ----- design/audio_frame_ring_buffer.sv -----
// channel | handshake                | payload
// --------+--------------------------+---------------------------------
// in      | in_valid / in_ready      | in_item  (afrb_pkg::in_item_t)
// out     | out_valid / out_ready    | out_item (afrb_pkg::out_item_t)
// cfg     | cfg_we                   | cfg_index, cfg_data
//
// Write frame: 1 cycle. Check write: 1 cycle plus one result beat.
// Read block of N frames: 1 accept cycle, then one result per cycle while
// out_ready is high (one registered RAM read per beat), so N + 1 cycles.
// Reset and clear run a sweep of DEPTH_FRAMES cycles over the sample RAMs,
// during which in_ready stays low; cfg writes are taken throughout.
// A stalled result holds; input is accepted only once all beats are taken.
module audio_frame_ring_buffer #(
    parameter int DEPTH_FRAMES = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_BLOCK    = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  afrb_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output afrb_pkg::out_item_t              out_item,
    input  logic                             cfg_we,
    input  logic [afrb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [afrb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import afrb_pkg::*;

    ctrl_t ctl;
    stat_t stat;

    afrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (in_item.command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    afrb_datapath #(
        .DEPTH_FRAMES (DEPTH_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BLOCK    (MAX_BLOCK)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .ctl       (ctl),
        .stat      (stat),
        .out_item  (out_item)
    );

endmodule
